// ===== design/srlt_pkg.sv =====
// Shared constants and control types for the source rate limit table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package srlt_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 32;
    localparam int TIME_W        = 32;
    localparam int WINDOW_W      = 23;
    localparam int SLOT_W        = 3;
    localparam int MS_PER_SEC    = 1000;
    localparam int WINDOW_RESET  = 60;

    localparam logic ACT_CHECK  = 1'b0;
    localparam logic ACT_RECORD = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } srlt_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } srlt_status_t;

endpackage

`default_nettype wire

// ===== design/srlt_ctrl.sv =====
// Controller state machine for the source rate limit table.
// Depends on srlt_pkg; drives the datapath through srlt_cmd_t.
`default_nettype none

module srlt_ctrl
    import srlt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire srlt_status_t status,
    output srlt_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/srlt_dpath.sv =====
// Datapath of the source rate limit table: key and time stores, scan unit,
// window limit register and result register. Depends on srlt_pkg.
`default_nettype none

module srlt_dpath
    import srlt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire srlt_cmd_t           cmd,
    output srlt_status_t             status,
    input  wire logic                cfg_valid,
    input  wire logic [WINDOW_W-1:0] cfg_data,
    input  wire logic                action,
    input  wire logic [KEY_W-1:0]    source_key,
    input  wire logic [TIME_W-1:0]   now_ms,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     limited,
    output logic [SLOT_W-1:0]        slot_used,
    output logic                     evicted
);

    logic [KEY_W-1:0]  key_mem [TABLE_ENTRIES];
    logic [TIME_W-1:0] time_mem [TABLE_ENTRIES];

    logic [TIME_W-1:0] limit_reg;
    logic [CNT_W-1:0]  used_count_reg;
    logic [CNT_W-1:0]  used_count_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic              act_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] now_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              hit_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic [TIME_W-1:0] min_reg;
    logic [IDX_W-1:0]  min_idx_reg;

    logic              limited_reg;
    logic [SLOT_W-1:0] slot_used_reg;
    logic              evicted_reg;

    logic [KEY_W-1:0]  key_rd_reg;
    logic [TIME_W-1:0] time_rd_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] age;
    logic              entry_live;
    logic              key_eq;
    logic              in_window;
    logic              table_full;
    logic              do_write;
    logic [IDX_W-1:0]  slot;

    assign rd_addr    = cmd.load ? '0 : idx_reg + IDX_W'(1);
    assign age        = now_reg - time_rd_reg;
    assign entry_live = CNT_W'(idx_reg) < used_count_reg;
    assign key_eq     = key_rd_reg == key_reg;
    assign in_window  = age < limit_reg;
    assign table_full = used_count_reg == CNT_W'(TABLE_ENTRIES);

    always_comb
    begin
        if (found_reg)
        begin
            slot = match_idx_reg;
        end
        else if (!table_full)
        begin
            slot = IDX_W'(used_count_reg);
        end
        else
        begin
            slot = min_idx_reg;
        end
    end

    assign do_write = cmd.finish && (act_reg == ACT_RECORD);

    always_comb
    begin
        used_count_next = used_count_reg;
        if (do_write && !found_reg && !table_full)
        begin
            used_count_next = used_count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign status.scan_last = idx_reg == IDX_W'(TABLE_ENTRIES - 1);
    assign status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= TIME_W'(WINDOW_RESET * MS_PER_SEC);
            used_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= TIME_W'(TIME_W'(cfg_data) * TIME_W'(MS_PER_SEC));
            end
            used_count_reg <= used_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            key_reg   <= source_key;
            now_reg   <= now_ms;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (entry_live && key_eq && in_window)
            begin
                hit_reg <= 1'b1;
            end
            if (entry_live && key_eq && !found_reg)
            begin
                found_reg     <= 1'b1;
                match_idx_reg <= idx_reg;
            end
            if (idx_reg == '0 || time_rd_reg < min_reg)
            begin
                min_reg     <= time_rd_reg;
                min_idx_reg <= idx_reg;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            key_mem[slot]  <= key_reg;
            time_mem[slot] <= now_reg;
        end
        key_rd_reg  <= key_mem[rd_addr];
        time_rd_reg <= time_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (act_reg == ACT_RECORD)
            begin
                limited_reg   <= 1'b0;
                slot_used_reg <= SLOT_W'(slot);
                evicted_reg   <= !found_reg && table_full;
            end
            else
            begin
                limited_reg   <= hit_reg;
                slot_used_reg <= '0;
                evicted_reg   <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign limited   = limited_reg;
    assign slot_used = slot_used_reg;
    assign evicted   = evicted_reg;

endmodule

`default_nettype wire

// ===== design/source_rate_limit_table_unit.sv =====
// Top level of the source rate limit table: joins controller and datapath.
// Depends on srlt_pkg, srlt_ctrl and srlt_dpath.
//
// Usage: an input item (action, source_key, now_ms) is taken on in_valid and
// in_ready. A check item returns limited; a record item stores the key and
// time and returns slot_used and evicted. Every item gives one result item on
// out_valid and out_ready.
// The window is written through cfg_valid and cfg_data; cfg_ready is always
// high, and the user must make writes only while no item is in flight; the
// block itself does not enforce this. The scan visits one table entry per
// cycle. One item is worked on at a time: a new item is accepted only after
// the current one is written back.
// The result waits in an output register; a new item is accepted and scanned
// while it waits, and the block holds before the write-back until the
// receiver takes the earlier result.
// Reset empties the table and sets the window to 60 seconds; the stores
// themselves are not cleared and need no clearing pass.
`default_nettype none

module source_rate_limit_table_unit
    import srlt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [WINDOW_W-1:0] cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                action,
    input  wire logic [KEY_W-1:0]    source_key,
    input  wire logic [TIME_W-1:0]   now_ms,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     limited,
    output logic [SLOT_W-1:0]        slot_used,
    output logic                     evicted
);

    srlt_cmd_t    cmd;
    srlt_status_t status;

    assign cfg_ready = 1'b1;

    srlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    srlt_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .action     (action),
        .source_key (source_key),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .limited    (limited),
        .slot_used  (slot_used),
        .evicted    (evicted)
    );

`ifndef SYNTH
    a_finish_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("write-back while the result register is occupied");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && cmd.step))
        else $error("scan did not start after an accepted item");

    a_limited_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && limited) |-> (slot_used == '0 && !evicted))
        else $error("record fields set on a limited check result");

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("result not presented after write-back");
`endif

endmodule

`default_nettype wire
